### src/tcn_pkg.sv
package tcn_pkg;

  localparam int unsigned TickW = 64;
  localparam int unsigned RateW = 32;
  localparam int unsigned ResW  = 30;

  // period divider: dividend is 1e9 + rate - 1, up to 33 bits, one bit per cycle
  localparam int unsigned PerDivW = RateW + 1;
  localparam int unsigned PerCntW = $clog2(PerDivW);

  localparam logic [ResW-1:0]  NsPerSec      = 30'd1000000000;
  localparam logic [RateW-1:0] RateAtReset   = 32'd1000000;
  localparam logic [ResW-1:0]  PeriodAtReset = 30'd1000;

  // rate register status handed from the period unit to the datapath
  typedef struct packed {
    logic             busy;
    logic [RateW-1:0] rate;
    logic [ResW-1:0]  period;
  } rate_status_t;

endpackage

### src/tcn_if.sv
interface tcn_tick_if;
  logic                      valid;
  logic                      ready;
  logic [tcn_pkg::TickW-1:0] tick_count;
  modport source (output valid, output tick_count, input ready);
  modport sink (input valid, input tick_count, output ready);
endinterface

interface tcn_res_if;
  logic                      valid;
  logic                      ready;
  logic [tcn_pkg::TickW-1:0] nanoseconds;
  logic [tcn_pkg::ResW-1:0]  resolution_ns;
  logic                      rate_valid;
  modport source (output valid, output nanoseconds, output resolution_ns, output rate_valid,
                  input ready);
  modport sink (input valid, input nanoseconds, input resolution_ns, input rate_valid,
                output ready);
endinterface

interface tcn_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [tcn_pkg::RateW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/tcn_period.sv
module tcn_period (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_valid_i,
  input  logic [tcn_pkg::RateW-1:0] wr_data_i,
  output logic                   wr_ready_o,
  output tcn_pkg::rate_status_t  status_o
);
  import tcn_pkg::*;

  logic [RateW-1:0]   rate_q;
  logic [ResW-1:0]    period_q;
  logic               busy_q;
  logic [PerCntW-1:0] cnt_q;
  logic [RateW-1:0]   rem_q;
  logic [PerDivW-1:0] quo_q;
  logic [PerDivW-1:0] trial;
  logic [PerDivW-1:0] diff;
  logic [RateW-1:0]   rem_d;
  logic [PerDivW-1:0] quo_d;

  // one restoring step of ceil(1e9 / rate)
  always_comb begin
    trial = {rem_q, quo_q[PerDivW-1]};
    diff  = trial - {1'b0, rate_q};
    quo_d = {quo_q[PerDivW-2:0], 1'b0};
    if (trial >= {1'b0, rate_q}) begin
      rem_d    = diff[RateW-1:0];
      quo_d[0] = 1'b1;
    end else begin
      rem_d = trial[RateW-1:0];
    end
  end

  // take a rate beat, then iterate until the period is known
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= RateAtReset;
      period_q <= PeriodAtReset;
      busy_q   <= 1'b0;
      cnt_q    <= '0;
    end else if (wr_valid_i && !busy_q) begin
      rate_q <= wr_data_i;
      cnt_q  <= '0;
      if (wr_data_i == '0) begin
        period_q <= '0;
      end else begin
        busy_q <= 1'b1;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == PerCntW'(PerDivW - 1)) begin
        busy_q   <= 1'b0;
        period_q <= quo_d[ResW-1:0];
      end
    end
  end

  // divider working registers
  always_ff @(posedge clk_i) begin
    if (wr_valid_i && !busy_q) begin
      rem_q <= '0;
      quo_q <= PerDivW'(NsPerSec) + PerDivW'(wr_data_i) - PerDivW'(1);
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign wr_ready_o      = !busy_q;
  assign status_o.busy   = busy_q;
  assign status_o.rate   = rate_q;
  assign status_o.period = period_q;

endmodule

### src/tcn_div_stage.sv
module tcn_div_stage #(
  parameter int unsigned QW    = 64,
  parameter int unsigned STEPS = 2,
  parameter int unsigned SW    = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [tcn_pkg::RateW-1:0] divisor_i,
  input  logic                      valid_i,
  input  logic [tcn_pkg::RateW-1:0] rem_i,
  input  logic [QW-1:0]             quo_i,
  input  logic [SW-1:0]             side_i,
  output logic                      valid_o,
  output logic [tcn_pkg::RateW-1:0] rem_o,
  output logic [QW-1:0]             quo_o,
  output logic [SW-1:0]             side_o
);
  import tcn_pkg::*;

  logic [RateW:0]   trial;
  logic [RateW:0]   diff;
  logic [RateW-1:0] rem_d;
  logic [QW-1:0]    quo_d;

  // restoring steps: dividend bits shift out the top, quotient bits in the bottom
  always_comb begin
    rem_d = rem_i;
    quo_d = quo_i;
    trial = '0;
    diff  = '0;
    for (int s = 0; s < STEPS; s++) begin
      trial = {rem_d, quo_d[QW-1]};
      diff  = trial - {1'b0, divisor_i};
      quo_d = {quo_d[QW-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d    = diff[RateW-1:0];
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[RateW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      quo_o  <= quo_d;
      side_o <= side_i;
    end
  end

endmodule

### src/tcn_mul.sv
module tcn_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [tcn_pkg::TickW-1:0] secs_i,
  input  logic [tcn_pkg::RateW-1:0] rem_i,
  input  logic                      ok_i,
  output logic                      valid_o,
  output logic [tcn_pkg::TickW-1:0] sec_ns_o,
  output logic [tcn_pkg::RateW+tcn_pkg::ResW-1:0] rem_ns_o,
  output logic                      ok_o
);
  import tcn_pkg::*;

  localparam int unsigned PW = RateW + ResW;

  logic          v1_q;
  logic          ok1_q;
  logic [PW-1:0] prem_q;
  logic [PW-1:0] plo_q;
  logic [RateW-1:0] phi_q;
  logic [PW-1:0] phi_full;

  assign phi_full = PW'(secs_i[TickW-1:RateW]) * PW'(NsPerSec);

  // first stage: three 32x30 products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prem_q <= PW'(rem_i) * PW'(NsPerSec);
      plo_q  <= PW'(secs_i[RateW-1:0]) * PW'(NsPerSec);
      phi_q  <= phi_full[RateW-1:0];
      ok1_q  <= ok_i;
    end
  end

  // second stage: assemble seconds times 1e9, modulo 2^64
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec_ns_o <= TickW'(plo_q) + {phi_q, {RateW{1'b0}}};
      rem_ns_o <= prem_q;
      ok_o     <= ok1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      valid_o <= v1_q;
    end
  end

endmodule

### src/tick_count_to_nanoseconds.sv
// Tick count to nanoseconds converter.
//
// cfg:  write beat sets the tick rate in hertz. A nonzero rate starts a
//       bit-serial divide for the tick period; cfg.ready and tick.ready
//       stay low until it ends. A zero rate takes effect at once.
// tick: one 64-bit tick count per beat.
// res:  one beat per tick beat, in order: nanoseconds, the period rounded up
//       (resolution_ns) and rate_valid. A zero rate gives zeros, rate_valid low.
//
// Throughput is one item per cycle unless res stalls or a period divide
// runs. A tick beat passes 32 stages of the tick/rate divider (two quotient
// bits each), two multiplier stages, 15 stages of the remainder divider and
// the output register on its way to res. Reset loads a rate of 1 MHz and a
// period of 1000 ns; nothing is in flight. When res is stalled the whole
// pipeline holds and tick.ready drops; no beat is lost or repeated. The user
// makes rate changes while nothing is in flight; the block does not check.
module tick_count_to_nanoseconds (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcn_cfg_if.sink    cfg,
  tcn_tick_if.sink   tick,
  tcn_res_if.source  res
);
  import tcn_pkg::*;

  localparam int unsigned DivSteps = 2;
  localparam int unsigned NumA     = TickW / DivSteps;
  localparam int unsigned NumB     = ResW / DivSteps;
  localparam int unsigned PW       = RateW + ResW;
  localparam int unsigned SideB    = TickW + 1;

  rate_status_t status;
  logic         en;

  logic                 va  [NumA+1];
  logic [RateW-1:0]     ra  [NumA+1];
  logic [TickW-1:0]     qa  [NumA+1];
  logic                 sa  [NumA+1];

  logic                 vm;
  logic [TickW-1:0]     sec_ns;
  logic [PW-1:0]        rem_ns;
  logic                 okm;

  logic                 vb  [NumB+1];
  logic [RateW-1:0]     rb  [NumB+1];
  logic [ResW-1:0]      qb  [NumB+1];
  logic [SideB-1:0]     sb  [NumB+1];

  logic                 out_valid_q;
  logic [TickW-1:0]     ns_q;
  logic                 ok_q;

  tcn_period u_period (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg.valid),
    .wr_data_i  (cfg.data),
    .wr_ready_o (cfg.ready),
    .status_o   (status)
  );

  // advance the pipeline whenever the output register is free or drains
  assign en         = !out_valid_q || res.ready;
  assign tick.ready = en && !status.busy;

  assign va[0] = tick.valid && !status.busy;
  assign ra[0] = '0;
  assign qa[0] = tick.tick_count;
  assign sa[0] = (status.rate != '0);

  // tick count divided by the rate
  for (genvar i = 0; i < NumA; i++) begin : g_div_a
    tcn_div_stage #(.QW(TickW), .STEPS(DivSteps), .SW(1)) u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .divisor_i (status.rate),
      .valid_i   (va[i]),
      .rem_i     (ra[i]),
      .quo_i     (qa[i]),
      .side_i    (sa[i]),
      .valid_o   (va[i+1]),
      .rem_o     (ra[i+1]),
      .quo_o     (qa[i+1]),
      .side_o    (sa[i+1])
    );
  end

  tcn_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (va[NumA]),
    .secs_i   (qa[NumA]),
    .rem_i    (ra[NumA]),
    .ok_i     (sa[NumA]),
    .valid_o  (vm),
    .sec_ns_o (sec_ns),
    .rem_ns_o (rem_ns),
    .ok_o     (okm)
  );

  // remainder times 1e9 divided by the rate; the quotient fits 30 bits
  assign vb[0] = vm;
  assign rb[0] = rem_ns[PW-1:ResW];
  assign qb[0] = rem_ns[ResW-1:0];
  assign sb[0] = {okm, sec_ns};

  for (genvar j = 0; j < NumB; j++) begin : g_div_b
    tcn_div_stage #(.QW(ResW), .STEPS(DivSteps), .SW(SideB)) u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .divisor_i (status.rate),
      .valid_i   (vb[j]),
      .rem_i     (rb[j]),
      .quo_i     (qb[j]),
      .side_i    (sb[j]),
      .valid_o   (vb[j+1]),
      .rem_o     (rb[j+1]),
      .quo_o     (qb[j+1]),
      .side_o    (sb[j+1])
    );
  end

  // output register: sum the two terms, drop to zero on a zero rate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vb[NumB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_q <= sb[NumB][TickW];
      ns_q <= sb[NumB][TickW] ? (sb[NumB][TickW-1:0] + TickW'(qb[NumB])) : '0;
    end
  end

  assign res.valid         = out_valid_q;
  assign res.nanoseconds   = ns_q;
  assign res.rate_valid    = ok_q;
  assign res.resolution_ns = status.period;

endmodule

### src/tcn_checker.sv
module tcn_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [tcn_pkg::RateW-1:0] cfg_data,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [tcn_pkg::TickW-1:0] nanoseconds,
  input logic [tcn_pkg::ResW-1:0]  resolution_ns,
  input logic                      rate_valid
);

  // hold a stalled result beat
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(nanoseconds))
    else $error("stalled result changed");

  // zero rate gives zero time and zero resolution
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !rate_valid |-> nanoseconds == '0 && resolution_ns == '0)
    else $error("zero rate result not zero");

  // a usable rate always has a nonzero period
  a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && rate_valid |-> resolution_ns != '0)
    else $error("zero resolution with valid rate");

  // a nonzero rate write blocks both channels while the period is computed
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid && cfg_ready && cfg_data != '0 |=> !in_ready && !cfg_ready)
    else $error("period computation not blocking");

endmodule

bind tick_count_to_nanoseconds tcn_checker u_tcn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_valid     (cfg.valid),
  .cfg_ready     (cfg.ready),
  .cfg_data      (cfg.data),
  .in_ready      (tick.ready),
  .out_valid     (res.valid),
  .out_ready     (res.ready),
  .nanoseconds   (res.nanoseconds),
  .resolution_ns (res.resolution_ns),
  .rate_valid    (res.rate_valid)
);

### sim/tick_count_to_nanoseconds_tb.sv
module tick_count_to_nanoseconds_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcn_pkg::*;

  localparam longint unsigned NsPerSecond = 64'd1000000000;
  localparam int unsigned     PipeDepth   = 60;
  localparam int unsigned     CycleLimit  = 400000;
  localparam int unsigned     PhaseItems  = 125;
  localparam int unsigned     NumPhases   = 10;

  typedef struct {
    logic [TickW-1:0] nanoseconds;
    logic [ResW-1:0]  resolution_ns;
    logic             rate_valid;
  } conversion_t;

  typedef struct {
    bit               is_rate_write;
    logic [RateW-1:0] rate;
    logic [TickW-1:0] tick_count;
    bit               typed;
    conversion_t      want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  tcn_cfg_if  cfg_bus ();
  tcn_tick_if tick_bus ();
  tcn_res_if  res_bus ();

  tick_count_to_nanoseconds i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg    (cfg_bus),
    .tick   (tick_bus),
    .res    (res_bus)
  );

  // predictor copy of the rate register and derived period
  logic [RateW-1:0] rate_hz;
  logic [ResW-1:0]  tick_period;

  conversion_t pending_conversions[$];
  int unsigned mismatches;
  int unsigned beats_checked;
  int unsigned rate_writes;
  int unsigned cycles;
  bit          calm;

  function automatic logic [ResW-1:0] period_for_rate(logic [RateW-1:0] hz);
    longint unsigned h;
    h = longint'(hz);
    if (h == 0) begin
      return '0;
    end
    return ResW'((NsPerSecond + h - 1) / h);
  endfunction

  function automatic conversion_t convert_ticks(logic [TickW-1:0] ticks);
    conversion_t     c;
    longint unsigned h;
    h = longint'(rate_hz);
    c.nanoseconds   = '0;
    c.rate_valid    = 1'b0;
    c.resolution_ns = tick_period;
    if (h != 0) begin
      c.nanoseconds = (ticks / h) * NsPerSecond + ((ticks % h) * NsPerSecond) / h;
      c.rate_valid  = 1'b1;
    end
    return c;
  endfunction

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles,
               pending_conversions.size());
      $display("tick_count_to_nanoseconds_tb: done, errors");
      $finish;
    end
  end

  // result sink: random stalls, compare each beat with the oldest prediction
  always @(posedge clk) begin
    conversion_t want;
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= calm || ($urandom_range(0, 99) >= 6);
      if (res_bus.valid && res_bus.ready) begin
        beats_checked <= beats_checked + 1;
        if (pending_conversions.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("unexpected result beat: ns %0d", res_bus.nanoseconds);
          end
        end else begin
          want = pending_conversions.pop_front();
          if (res_bus.nanoseconds !== want.nanoseconds ||
              res_bus.resolution_ns !== want.resolution_ns ||
              res_bus.rate_valid !== want.rate_valid) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("mismatch: ns %0d/%0d res %0d/%0d valid %0b/%0b (exp/act)",
                       want.nanoseconds, res_bus.nanoseconds, want.resolution_ns,
                       res_bus.resolution_ns, want.rate_valid, res_bus.rate_valid);
            end
          end
        end
      end
    end
  end

  // hand one tick beat to the block, holding valid high across back-to-back beats
  task automatic send_ticks(logic [TickW-1:0] ticks, bit typed, conversion_t typed_want);
    if (!calm && $urandom_range(0, 99) < 6) begin
      tick_bus.valid <= 1'b0;
      @(posedge clk);
    end
    tick_bus.valid      <= 1'b1;
    tick_bus.tick_count <= ticks;
    pending_conversions.push_back(typed ? typed_want : convert_ticks(ticks));
    do @(posedge clk); while (!tick_bus.ready);
  endtask

  // drain, let the pipeline settle, then write the rate
  task automatic write_rate(logic [RateW-1:0] hz);
    tick_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_conversions.size() != 0) @(posedge clk);
    repeat (PipeDepth) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= hz;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    rate_hz     = hz;
    tick_period = period_for_rate(hz);
    rate_writes = rate_writes + 1;
  endtask

  function automatic stim_row_t tick_row(logic [TickW-1:0] t);
    stim_row_t r;
    r = '{default: '0};
    r.tick_count = t;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [TickW-1:0] t, logic [TickW-1:0] ns,
                                          logic [ResW-1:0] res, logic ok);
    stim_row_t r;
    r = tick_row(t);
    r.typed = 1'b1;
    r.want  = '{ns, res, ok};
    return r;
  endfunction

  function automatic stim_row_t rate_row(logic [RateW-1:0] hz);
    stim_row_t r;
    r = '{default: '0};
    r.is_rate_write = 1'b1;
    r.rate          = hz;
    return r;
  endfunction

  function automatic logic [TickW-1:0] random_ticks();
    logic [TickW-1:0] r;
    case ($urandom_range(0, 9))
      5:       r = TickW'($urandom_range(0, 5000));
      6:       r = TickW'(rate_hz) * $urandom_range(0, 100000) +
                   ($urandom_range(0, 1) ? TickW'(rate_hz) - 1 : 0);
      7:       r = ~TickW'($urandom_range(0, 5));
      8:       r = {32'h0, $urandom()};
      9:       r = {$urandom(), $urandom()} & {$urandom(), $urandom()};
      default: r = {$urandom(), $urandom()};
    endcase
    return r;
  endfunction

  function automatic logic [RateW-1:0] rate_for_phase(int unsigned p);
    case (p)
      0:       return 32'd1;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd0;
      3:       return 32'd1000000000;
      4:       return 32'd1000000001;
      5:       return RateW'($urandom_range(2, 1000));
      6:       return RateW'($urandom_range(1000, 100000000));
      7:       return RateAtReset;
      default: return $urandom();
    endcase
  endfunction

  stim_row_t directed[$];

  initial begin
    conversion_t none;
    none = '{default: '0};
    rst_n               <= 1'b0;
    calm                = 1'b0;
    mismatches          = 0;
    beats_checked       = 0;
    rate_writes         = 0;
    cycles              = 0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.data        <= '0;
    tick_bus.valid      <= 1'b0;
    tick_bus.tick_count <= '0;
    rate_hz     = RateAtReset;
    tick_period = PeriodAtReset;

    // directed rows: reset rate, zero rate, 1 Hz, top rate, 1 GHz, 3 Hz
    directed.push_back(typed_row(64'd0, 64'd0, 30'd1000, 1'b1));
    directed.push_back(typed_row(64'd1, 64'd1000, 30'd1000, 1'b1));
    directed.push_back(typed_row(64'd1000000, 64'd1000000000, 30'd1000, 1'b1));
    directed.push_back(tick_row('1));
    directed.push_back(rate_row(32'd0));
    directed.push_back(typed_row('1, 64'd0, 30'd0, 1'b0));
    directed.push_back(typed_row(64'd0, 64'd0, 30'd0, 1'b0));
    directed.push_back(rate_row(32'd1));
    directed.push_back(typed_row(64'd1, 64'd1000000000, 30'd1000000000, 1'b1));
    directed.push_back(tick_row('1));
    directed.push_back(tick_row(64'h8000_0000_0000_0000));
    directed.push_back(rate_row(32'hFFFF_FFFF));
    directed.push_back(typed_row(64'hFFFF_FFFF, 64'd1000000000, 30'd1, 1'b1));
    directed.push_back(tick_row(64'hFFFF_FFFE));
    directed.push_back(tick_row('1));
    directed.push_back(rate_row(32'd1000000000));
    directed.push_back(typed_row(64'd12345, 64'd12345, 30'd1, 1'b1));
    directed.push_back(rate_row(32'd3));
    directed.push_back(tick_row(64'd2));
    directed.push_back(tick_row(64'h5555_5555_5555_5555));
    directed.push_back(tick_row(64'hAAAA_AAAA_AAAA_AAAA));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    foreach (directed[i]) begin
      if (directed[i].is_rate_write) begin
        write_rate(directed[i].rate);
      end else begin
        send_ticks(directed[i].tick_count, directed[i].typed, directed[i].want);
      end
    end

    // random phases, one rate setting each; one phase runs without stalls
    for (int unsigned p = 0; p < NumPhases; p++) begin
      write_rate(rate_for_phase(p));
      calm = (p == 7);
      for (int unsigned k = 0; k < PhaseItems; k++) begin
        send_ticks(random_ticks(), 1'b0, none);
      end
      calm = 1'b0;
    end

    // drain and settle
    tick_bus.valid <= 1'b0;
    while (pending_conversions.size() != 0) @(posedge clk);
    repeat (PipeDepth) @(posedge clk);

    $display("checked %0d conversion beats across %0d rate writes, %0d mismatches",
             beats_checked, rate_writes, mismatches);
    if (mismatches == 0) begin
      $display("tick_count_to_nanoseconds_tb: done, clean");
    end else begin
      $display("tick_count_to_nanoseconds_tb: done, errors");
    end
    $finish;
  end

endmodule

### tick_count_to_nanoseconds.f
src/tcn_pkg.sv
src/tcn_if.sv
src/tcn_period.sv
src/tcn_div_stage.sv
src/tcn_mul.sv
src/tick_count_to_nanoseconds.sv
src/tcn_checker.sv
sim/tick_count_to_nanoseconds_tb.sv
